### src/binary_max_heap_unit_defines.svh
// ----------------------------------------------------------------------------
// binary_max_heap_unit_defines
// assertion macros shared by the heap unit, sampled on i_clk with reset low
// disabling every check
// ----------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_UNIT_DEFINES_SVH
`define BINARY_MAX_HEAP_UNIT_DEFINES_SVH

// same-cycle implication
`define BMH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BMH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/bmh_pkg.sv
// ----------------------------------------------------------------------------
// bmh_pkg
// types, codes and default sizes for the binary max-heap unit
// ----------------------------------------------------------------------------
package bmh_pkg;

    // default number of heap slots
    localparam int CAPACITY_DEF = 256;

    // fixed field widths
    localparam int KEY_W    = 32;
    localparam int IDX_W    = 8;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 9;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
    localparam logic [OP_W-1:0] OP_EXTRACT  = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE   = 2'd2;
    localparam logic [OP_W-1:0] OP_DECREASE = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RAISE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE = 3'd4;

    // one request
    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic signed [KEY_W-1:0] key_value;
        logic [IDX_W-1:0]        slot_index;
    } t_request;

    // one result
    typedef struct packed {
        logic signed [KEY_W-1:0] result_value;
        logic [STATUS_W-1:0]     status;
        logic [COUNT_W-1:0]      entry_count;
    } t_result;

endpackage

### src/binary_max_heap_unit.sv
// ----------------------------------------------------------------------------
// binary_max_heap_unit
// priority queue of signed keys kept as a binary max-heap in one memory
// ----------------------------------------------------------------------------
// A request (opcode, key_value, slot_index) is taken at a rising edge with
// start high and busy low. Each request gives exactly one result on o_result,
// shown for a single cycle with o_done high; the receiver cannot stall it.
// busy is low again in the cycle o_done is high, so the next request may be
// taken there.
// Steps from the accepting edge to the o_done cycle:
//   full, empty and range errors: answered from idle; refused raise: after the slot's key is read
//   insert: written straight from idle into an empty heap, else sifts up level by level
//   extract: reads the root, fetches the last entry, then sifts it down from the root
//   delete: as extract, after shifting each ancestor of the slot down one level
//   decrease: checks the key at the slot, then sifts down from the slot
// The rate is set by the single read and single write port of the key
// memory: sift-down needs two child reads per level.
// Reset clears the entry count and the control state; the key memory is not
// cleared, since only keys in slots below the count are ever used.
// ----------------------------------------------------------------------------
`include "binary_max_heap_unit_defines.svh"

module binary_max_heap_unit
    import bmh_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_request i_request,
    output logic     o_done,
    output t_result  o_result
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int XW   = CW + 1;
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

    // controller states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SU_CMP = 4'd1;
    localparam logic [3:0] S_EX_TOP = 4'd2;
    localparam logic [3:0] S_DL_VAL = 4'd3;
    localparam logic [3:0] S_DL_UP  = 4'd4;
    localparam logic [3:0] S_TAIL   = 4'd5;
    localparam logic [3:0] S_LAST   = 4'd6;
    localparam logic [3:0] S_DC_CHK = 4'd7;
    localparam logic [3:0] S_SD_RL  = 4'd8;
    localparam logic [3:0] S_SD_RR  = 4'd9;
    localparam logic [3:0] S_SD_CMP = 4'd10;
    localparam logic [3:0] S_FIN    = 4'd11;

    logic [3:0]              r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [AW-1:0]           r_hole, n_hole;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic signed [KEY_W-1:0] r_lval, n_lval;
    logic signed [KEY_W-1:0] r_value, n_value;
    logic [STATUS_W-1:0]     r_status, n_status;
    logic                    r_done, n_done;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [KEY_W-1:0]        mem_wdata;
    logic [AW-1:0]           mem_raddr;
    logic [KEY_W-1:0]        mem_rdata;
    logic signed [KEY_W-1:0] rd_key;

    logic                    accept;
    logic [AW-1:0]           w_par, w_grand;
    logic [AW-1:0]           w_ins_pos, w_ins_par;
    logic [XW-1:0]           w_lchild, w_rchild, w_count_x;
    logic                    w_l_gt, w_r_gt;
    logic signed [KEY_W-1:0] w_best_v;
    logic [AW-1:0]           w_new_hole;
    logic [XW-1:0]           w_new_l;
    logic [CMPW-1:0]         w_idx_ext, w_count_ext;

    // key memory
    bmh_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_key = $signed(mem_rdata);
    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // heap index arithmetic around the hole
    assign w_par       = (r_hole - AW'(1)) >> 1;
    assign w_grand     = (w_par - AW'(1)) >> 1;
    assign w_ins_pos   = AW'(r_count);
    assign w_ins_par   = (w_ins_pos - AW'(1)) >> 1;
    assign w_lchild    = XW'({r_hole, 1'b1});
    assign w_rchild    = XW'({r_hole, 1'b0}) + XW'(2);
    assign w_count_x   = XW'(r_count);
    assign w_idx_ext   = CMPW'(i_request.slot_index);
    assign w_count_ext = CMPW'(r_count);

    // child selection for sift-down
    assign w_l_gt     = r_lval > r_key;
    assign w_best_v   = w_l_gt ? r_lval : r_key;
    assign w_r_gt     = (w_rchild < w_count_x) && (rd_key > w_best_v);
    assign w_new_hole = w_r_gt ? AW'(w_rchild) : AW'(w_lchild);
    assign w_new_l    = XW'({w_new_hole, 1'b1});

    // controller
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_hole    = r_hole;
        n_key     = r_key;
        n_lval    = r_lval;
        n_value   = r_value;
        n_status  = r_status;
        n_done    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_hole;
        mem_wdata = r_key;
        mem_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_value  = '0;
                    n_status = ST_OK;
                    n_key    = i_request.key_value;
                    n_hole   = AW'(i_request.slot_index);
                    mem_raddr = AW'(i_request.slot_index);
                    unique case (i_request.opcode)
                        OP_INSERT: begin
                            if (r_count >= CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_done   = 1'b1;
                            end else if (r_count == '0) begin
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = i_request.key_value;
                                n_count   = r_count + CW'(1);
                                n_done    = 1'b1;
                            end else begin
                                n_hole    = w_ins_pos;
                                mem_raddr = w_ins_par;
                                n_count   = r_count + CW'(1);
                                n_state   = S_SU_CMP;
                            end
                        end
                        OP_EXTRACT: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_done   = 1'b1;
                            end else begin
                                mem_raddr = '0;
                                n_state   = S_EX_TOP;
                            end
                        end
                        OP_DELETE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_done   = 1'b1;
                            end else if (w_idx_ext >= w_count_ext) begin
                                n_status = ST_RANGE;
                                n_done   = 1'b1;
                            end else begin
                                n_state = S_DL_VAL;
                            end
                        end
                        OP_DECREASE: begin
                            if (w_idx_ext >= w_count_ext) begin
                                n_status = ST_RANGE;
                                n_done   = 1'b1;
                            end else begin
                                n_state = S_DC_CHK;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end

            // sift-up: parent read is in, move it down or settle
            S_SU_CMP: begin
                mem_raddr = w_grand;
                mem_we    = 1'b1;
                if (r_key > rd_key) begin
                    mem_wdata = rd_key;
                    n_hole    = w_par;
                    if (w_par == '0) begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end

            // extract: root value is in
            S_EX_TOP: begin
                n_value = rd_key;
                n_state = S_TAIL;
            end

            // delete: key at the slot is in
            S_DL_VAL: begin
                n_value = rd_key;
                if (r_hole == '0) begin
                    n_state = S_TAIL;
                end else begin
                    mem_raddr = w_par;
                    n_state   = S_DL_UP;
                end
            end

            // delete: shift each ancestor down one level towards the slot
            S_DL_UP: begin
                mem_we    = 1'b1;
                mem_wdata = rd_key;
                mem_raddr = w_grand;
                n_hole    = w_par;
                if (w_par == '0) begin
                    n_state = S_TAIL;
                end
            end

            // shrink the count and fetch the last entry
            S_TAIL: begin
                mem_raddr = AW'(r_count - CW'(1));
                n_count   = r_count - CW'(1);
                n_state   = S_LAST;
            end

            S_LAST: begin
                n_key   = rd_key;
                n_hole  = '0;
                n_state = S_SD_RL;
            end

            // decrease: refuse a larger key
            S_DC_CHK: begin
                if (r_key > rd_key) begin
                    n_status = ST_RAISE;
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                end else begin
                    n_state = S_SD_RL;
                end
            end

            // sift-down: fetch left child or settle at a leaf
            S_SD_RL: begin
                mem_raddr = AW'(w_lchild);
                if (w_lchild < w_count_x) begin
                    n_state = S_SD_RR;
                end else begin
                    mem_we  = 1'b1;
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end

            // sift-down: left child in, fetch right child
            S_SD_RR: begin
                n_lval    = rd_key;
                mem_raddr = AW'(w_rchild);
                n_state   = S_SD_CMP;
            end

            // sift-down: pick the larger child or settle
            S_SD_CMP: begin
                mem_we = 1'b1;
                if (w_l_gt || w_r_gt) begin
                    mem_wdata = w_r_gt ? rd_key : r_lval;
                    n_hole    = w_new_hole;
                    mem_raddr = AW'(w_new_l);
                    if (w_new_l < w_count_x) begin
                        n_state = S_SD_RR;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end

            // place the moving key in the hole
            S_FIN: begin
                mem_we  = 1'b1;
                n_state = S_IDLE;
                n_done  = 1'b1;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_hole   <= n_hole;
        r_key    <= n_key;
        r_lval   <= n_lval;
        r_value  <= n_value;
        r_status <= n_status;
    end

    assign o_done                = r_done;
    assign o_result.result_value = r_value;
    assign o_result.status       = r_status;
    assign o_result.entry_count  = COUNT_W'(r_count);

    // checks
    `BMH_ASSERT_NOW(a_done_idle, o_done, !busy, "result shown while still busy")
    `BMH_ASSERT_NEXT(a_accept_moves, accept, o_done || busy, "request taken but dropped")
    `BMH_ASSERT_NOW(a_full_count, o_done && (r_status == ST_FULL),
        r_count == CW'(CAPACITY), "full reported below capacity")
    `BMH_ASSERT_NOW(a_err_zero, o_done && (r_status != ST_OK),
        r_value == '0, "error result carries a value")

endmodule

### src/bmh_store.sv
// ----------------------------------------------------------------------------
// bmh_store
// heap key memory: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module bmh_store
    import bmh_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int AW    = $clog2(CAPACITY_DEF)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [KEY_W-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [KEY_W-1:0] o_rdata
);

    logic [KEY_W-1:0] r_mem [DEPTH];
    logic [KEY_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
